[design/linear_probe_hash_table_defines.svh]
// assertion macros shared by the hash table rtl
// expects signals named clock and reset in the module that uses them
`ifndef LINEAR_PROBE_HASH_TABLE_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define LPHT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define LPHT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/lpht_pkg.sv]
// types, constants and helper functions of the hash table
// used by lpht_ctrl, lpht_datapath and linear_probe_hash_table
`default_nettype none
package lpht_pkg;

   localparam int DEF_MAX_SLOTS     = 1024;
   localparam int DEF_INITIAL_SLOTS = 32;
   localparam int KEY_BYTES         = 8;

   localparam int ACTION_W    = 3;
   localparam int KEY_W       = 64;
   localparam int LEN_W       = 4;
   localparam int VALUE_W     = 32;
   localparam int STATUS_W    = 3;
   localparam int OUT_COUNT_W = 11;
   localparam int THR_W       = 7;
   localparam int HASH_W      = 16;

   localparam int REQ_W         = 104;
   localparam int REQ_KEY_LSB   = 3;
   localparam int REQ_LEN_LSB   = 67;
   localparam int REQ_VAL_LSB   = 71;
   localparam int RSP_W         = 64;
   localparam int RSP_USED_W    = 57;

   localparam logic [THR_W-1:0]  THR_RESET = 7'd60;
   localparam logic [HASH_W-1:0] DJB2_SEED = 16'd5381;
   localparam int LOAD_PERCENT = 100;

   typedef enum logic [2:0] {
      ACT_GET    = 3'd0,
      ACT_INSERT = 3'd1,
      ACT_UPDATE = 3'd2,
      ACT_SET    = 3'd3,
      ACT_DELETE = 3'd4
   } action_type;

   typedef enum logic [2:0] {
      STS_OK          = 3'd0,
      STS_NOT_FOUND   = 3'd1,
      STS_EXISTS      = 3'd2,
      STS_FULL        = 3'd3,
      STS_RESIZE_FAIL = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      MARK_EMPTY = 2'd0,
      MARK_USED  = 2'd1,
      MARK_TOMB  = 2'd2
   } mark_type;

   typedef enum logic [2:0] {
      OUT_FOUND,
      OUT_SLOT,
      OUT_NONE,
      OUT_RESIZE_FAIL,
      OUT_BAD
   } outcome_type;

   typedef enum logic [1:0] {
      RD_NONE,
      RD_WALK,
      RD_NEW,
      RD_CUR
   } rd_sel_type;

   typedef enum logic [1:0] {
      CLS_LOOKUP,
      CLS_STORE,
      CLS_BAD
   } act_class_type;

   typedef struct packed {
      logic        capture;
      logic        idx_zero;
      logic        idx_step;
      logic        clr_write;
      logic        clr_new;
      rd_sel_type  rd_sel;
      logic        walk_take;
      logic        place;
      logic        pos_step;
      logic        gpos_step;
      logic        probe_init;
      logic        commit;
      logic        apply;
      outcome_type outcome;
   } cmd_type;

   typedef struct packed {
      logic [1:0]    mark;
      logic          key_match;
      logic          have_tomb;
      logic          probe_last;
      logic          idx_last_cur;
      logic          idx_last_new;
      logic          need_grow;
      logic          can_grow;
      act_class_type act_class;
      logic          rsp_busy;
   } sts_type;

   // low bits of djb2; the low bits never depend on higher ones
   function automatic logic [HASH_W-1:0] djb2_low(input logic [KEY_W-1:0] key,
                                                  input logic [LEN_W-1:0] len);
      logic [HASH_W-1:0] h;
      h = DJB2_SEED;
      for (int i = 0; i < KEY_BYTES; i++) begin
         if (LEN_W'(i) < len) begin
            h = (h << 5) + h + HASH_W'(key[8*i +: 8]);
         end
      end
      return h;
   endfunction

   function automatic logic [KEY_W-1:0] key_mask(input logic [LEN_W-1:0] len);
      logic [KEY_W-1:0] m;
      m = '0;
      for (int i = 0; i < KEY_BYTES; i++) begin
         m[8*i +: 8] = (LEN_W'(i) < len) ? 8'hFF : 8'h00;
      end
      return m;
   endfunction

   // log2 of the largest power of two within both limits
   function automatic int init_log(input int init_slots, input int max_slots);
      int k;
      k = 0;
      for (int j = 0; j < 31; j++) begin
         if ((2 << k) <= init_slots && (2 << k) <= max_slots) begin
            k = k + 1;
         end
      end
      return k;
   endfunction

endpackage
`default_nettype wire

[design/lpht_ctrl.sv]
// control state machine of the hash table
// depends on lpht_pkg and linear_probe_hash_table_defines.svh
`default_nettype none
`include "linear_probe_hash_table_defines.svh"
module lpht_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire lpht_pkg::sts_type sts_i,
   output lpht_pkg::cmd_type     cmd_o
);
   import lpht_pkg::*;

   typedef enum logic [11:0] {
      ST_CLEAR   = 12'b0000_0000_0001,
      ST_IDLE    = 12'b0000_0000_0010,
      ST_DECIDE  = 12'b0000_0000_0100,
      ST_GCLR    = 12'b0000_0000_1000,
      ST_WRD     = 12'b0000_0001_0000,
      ST_WCHK    = 12'b0000_0010_0000,
      ST_GPRD    = 12'b0000_0100_0000,
      ST_GPCHK   = 12'b0000_1000_0000,
      ST_GCOMMIT = 12'b0001_0000_0000,
      ST_PINIT   = 12'b0010_0000_0000,
      ST_PRD     = 12'b0100_0000_0000,
      ST_PCHK    = 12'b1000_0000_0000
   } state_type;

   state_type   state_ff, state_in;
   outcome_type outcome_ff, outcome_in;
   logic        done_ff, done_in;

   assign req_tready = (state_ff == ST_IDLE) && !done_ff;

   always_comb begin
      state_in   = state_ff;
      outcome_in = outcome_ff;
      done_in    = done_ff;
      cmd_o         = '0;
      cmd_o.rd_sel  = RD_NONE;
      cmd_o.outcome = outcome_ff;
      if (done_ff) begin
         // result waits for a free output register
         if (!sts_i.rsp_busy) begin
            cmd_o.apply = 1'b1;
            done_in     = 1'b0;
            state_in    = ST_IDLE;
         end
      end else begin
         case (state_ff)
            ST_CLEAR: begin
               cmd_o.clr_write = 1'b1;
               cmd_o.idx_step  = 1'b1;
               if (sts_i.idx_last_cur) state_in = ST_IDLE;
            end
            ST_IDLE: begin
               if (req_tvalid) begin
                  cmd_o.capture = 1'b1;
                  state_in      = ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               case (sts_i.act_class)
                  CLS_LOOKUP: begin
                     cmd_o.probe_init = 1'b1;
                     state_in         = ST_PRD;
                  end
                  CLS_STORE: begin
                     if (sts_i.need_grow) begin
                        if (sts_i.can_grow) begin
                           cmd_o.idx_zero = 1'b1;
                           state_in       = ST_GCLR;
                        end else begin
                           outcome_in = OUT_RESIZE_FAIL;
                           done_in    = 1'b1;
                           state_in   = ST_IDLE;
                        end
                     end else begin
                        cmd_o.probe_init = 1'b1;
                        state_in         = ST_PRD;
                     end
                  end
                  default: begin
                     outcome_in = OUT_BAD;
                     done_in    = 1'b1;
                     state_in   = ST_IDLE;
                  end
               endcase
            end
            ST_GCLR: begin
               cmd_o.clr_write = 1'b1;
               cmd_o.clr_new   = 1'b1;
               if (sts_i.idx_last_new) begin
                  cmd_o.idx_zero = 1'b1;
                  state_in       = ST_WRD;
               end else begin
                  cmd_o.idx_step = 1'b1;
               end
            end
            ST_WRD: begin
               cmd_o.rd_sel = RD_WALK;
               state_in     = ST_WCHK;
            end
            ST_WCHK: begin
               if (sts_i.mark == MARK_USED) begin
                  cmd_o.walk_take = 1'b1;
                  state_in        = ST_GPRD;
               end else if (sts_i.idx_last_cur) begin
                  state_in = ST_GCOMMIT;
               end else begin
                  cmd_o.idx_step = 1'b1;
                  state_in       = ST_WRD;
               end
            end
            ST_GPRD: begin
               cmd_o.rd_sel = RD_NEW;
               state_in     = ST_GPCHK;
            end
            ST_GPCHK: begin
               if (sts_i.mark == MARK_EMPTY) begin
                  cmd_o.place = 1'b1;
                  if (sts_i.idx_last_cur) begin
                     state_in = ST_GCOMMIT;
                  end else begin
                     cmd_o.idx_step = 1'b1;
                     state_in       = ST_WRD;
                  end
               end else begin
                  cmd_o.gpos_step = 1'b1;
                  state_in        = ST_GPRD;
               end
            end
            ST_GCOMMIT: begin
               cmd_o.commit = 1'b1;
               state_in     = ST_PINIT;
            end
            ST_PINIT: begin
               cmd_o.probe_init = 1'b1;
               state_in         = ST_PRD;
            end
            ST_PRD: begin
               cmd_o.rd_sel = RD_CUR;
               state_in     = ST_PCHK;
            end
            ST_PCHK: begin
               if (sts_i.mark == MARK_EMPTY) begin
                  outcome_in = OUT_SLOT;
                  done_in    = 1'b1;
                  state_in   = ST_IDLE;
               end else if (sts_i.mark == MARK_TOMB) begin
                  if (sts_i.probe_last) begin
                     outcome_in = OUT_SLOT;
                     done_in    = 1'b1;
                     state_in   = ST_IDLE;
                  end else begin
                     cmd_o.pos_step = 1'b1;
                     state_in       = ST_PRD;
                  end
               end else if (sts_i.key_match) begin
                  outcome_in = OUT_FOUND;
                  done_in    = 1'b1;
                  state_in   = ST_IDLE;
               end else if (sts_i.probe_last) begin
                  outcome_in = sts_i.have_tomb ? OUT_SLOT : OUT_NONE;
                  done_in    = 1'b1;
                  state_in   = ST_IDLE;
               end else begin
                  cmd_o.pos_step = 1'b1;
                  state_in       = ST_PRD;
               end
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         outcome_ff <= OUT_BAD;
         done_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         outcome_ff <= outcome_in;
         done_ff    <= done_in;
      end
   end

   `LPHT_ASSERT_NOW(a_apply_free, cmd_o.apply, !sts_i.rsp_busy, "result applied over a held one")
   `LPHT_ASSERT_NEXT(a_cap_decide, cmd_o.capture, state_ff == ST_DECIDE, "request not decided")
   `LPHT_ASSERT_NEXT(a_commit_probe, cmd_o.commit, state_ff == ST_PINIT, "grow not followed by probe")

endmodule
`default_nettype wire

[design/lpht_datapath.sv]
// slot stores, probe and rebuild counters, request and result registers
// depends on lpht_pkg and linear_probe_hash_table_defines.svh
`default_nettype none
`include "linear_probe_hash_table_defines.svh"
module lpht_datapath #(
   parameter int MAX_SLOTS = lpht_pkg::DEF_MAX_SLOTS,
   parameter int INIT_LOG  = 5
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_valid,
   input  wire logic [lpht_pkg::THR_W-1:0]    csr_data,
   input  wire logic [lpht_pkg::REQ_W-1:0]    req_tdata,
   input  wire logic                          rsp_tready,
   output logic                               rsp_tvalid,
   output logic [lpht_pkg::RSP_W-1:0]         rsp_tdata,
   input  wire lpht_pkg::cmd_type             cmd_i,
   output lpht_pkg::sts_type                  sts_o
);
   import lpht_pkg::*;

   localparam int SLOT_BITS = $clog2(MAX_SLOTS);
   localparam int ADDR_W    = SLOT_BITS + 1;
   localparam int N_W       = SLOT_BITS + 1;
   localparam int CNT_W     = SLOT_BITS + 1;
   localparam int LOG_W     = $clog2(SLOT_BITS + 1);
   localparam int CMP_W     = CNT_W + THR_W + 1;
   localparam int DEPTH     = 2 * MAX_SLOTS;

   // two banks, the rebuild fills the idle one
   logic [1:0]         mark_mem [DEPTH];
   logic [KEY_W-1:0]   key_mem  [DEPTH];
   logic [LEN_W-1:0]   len_mem  [DEPTH];
   logic [VALUE_W-1:0] val_mem  [DEPTH];

   logic [THR_W-1:0]     thr_ff, thr_in;
   logic [LOG_W-1:0]     size_log_ff, size_log_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 bank_ff, bank_in;
   logic [SLOT_BITS-1:0] idx_ff, idx_in;
   logic [SLOT_BITS-1:0] pos_ff, pos_in;
   logic [SLOT_BITS-1:0] steps_ff, steps_in;
   logic                 have_tomb_ff, have_tomb_in;
   logic [SLOT_BITS-1:0] tomb_ff, tomb_in;
   logic [ACTION_W-1:0]  act_ff, act_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic [VALUE_W-1:0]   val_ff, val_in;
   logic [KEY_W-1:0]     ent_key_ff, ent_key_in;
   logic [LEN_W-1:0]     ent_len_ff, ent_len_in;
   logic [VALUE_W-1:0]   ent_val_ff, ent_val_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_USED_W-1:0] rsp_data_ff, rsp_data_in;

   logic [1:0]         rd_mark_ff;
   logic [KEY_W-1:0]   rd_key_ff;
   logic [LEN_W-1:0]   rd_len_ff;
   logic [VALUE_W-1:0] rd_val_ff;

   logic [N_W-1:0]       n_cur;
   logic [SLOT_BITS-1:0] mask_cur, mask_new, req_home, ent_home, target;
   logic [LEN_W-1:0]     cap_len;
   logic [KEY_W-1:0]     cap_key;
   logic                 rd_en;
   logic [ADDR_W-1:0]    rd_addr, wr_addr;
   logic                 we_mark, we_kv, we_val;
   logic [1:0]           wr_mark;
   logic [KEY_W-1:0]     wr_key;
   logic [LEN_W-1:0]     wr_len;
   logic [VALUE_W-1:0]   wr_val;
   status_type           rsp_status;
   logic [VALUE_W-1:0]   rsp_value;
   act_class_type        act_class;
   logic [CMP_W-1:0]     load_lhs, load_rhs;

   assign n_cur    = N_W'(1) << size_log_ff;
   assign mask_cur = SLOT_BITS'(n_cur - N_W'(1));
   assign mask_new = {mask_cur[SLOT_BITS-2:0], 1'b1};
   assign req_home = SLOT_BITS'(djb2_low(key_ff, len_ff)) & mask_cur;
   assign ent_home = SLOT_BITS'(djb2_low(rd_key_ff, rd_len_ff)) & mask_new;
   assign target   = have_tomb_ff ? tomb_ff : pos_ff;
   assign load_lhs = CMP_W'(count_ff) * CMP_W'(LOAD_PERCENT);
   assign load_rhs = CMP_W'(thr_ff) << size_log_ff;

   assign cap_len = (req_tdata[REQ_LEN_LSB +: LEN_W] > LEN_W'(KEY_BYTES)) ?
                    LEN_W'(KEY_BYTES) : req_tdata[REQ_LEN_LSB +: LEN_W];
   assign cap_key = req_tdata[REQ_KEY_LSB +: KEY_W] & key_mask(cap_len);

   always_comb begin
      if (act_ff == ACT_GET || act_ff == ACT_UPDATE || act_ff == ACT_DELETE) begin
         act_class = CLS_LOOKUP;
      end else if (act_ff == ACT_INSERT || act_ff == ACT_SET) begin
         act_class = CLS_STORE;
      end else begin
         act_class = CLS_BAD;
      end
   end

   always_comb begin
      sts_o.mark         = rd_mark_ff;
      sts_o.key_match    = (rd_key_ff == key_ff) && (rd_len_ff == len_ff);
      sts_o.have_tomb    = have_tomb_ff;
      sts_o.probe_last   = (steps_ff == mask_cur);
      sts_o.idx_last_cur = (idx_ff == mask_cur);
      sts_o.idx_last_new = (idx_ff == mask_new);
      sts_o.need_grow    = (load_lhs >= load_rhs);
      sts_o.can_grow     = (size_log_ff < LOG_W'(SLOT_BITS));
      sts_o.act_class    = act_class;
      sts_o.rsp_busy     = rsp_valid_ff && !rsp_tready;
   end

   // read port
   always_comb begin
      rd_en   = 1'b1;
      rd_addr = {bank_ff, pos_ff};
      case (cmd_i.rd_sel)
         RD_WALK: rd_addr = {bank_ff, idx_ff};
         RD_NEW:  rd_addr = {!bank_ff, pos_ff};
         RD_CUR:  rd_addr = {bank_ff, pos_ff};
         default: rd_en = 1'b0;
      endcase
   end

   always_comb begin
      thr_in       = csr_valid ? csr_data : thr_ff;
      size_log_in  = size_log_ff;
      count_in     = count_ff;
      bank_in      = bank_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      steps_in     = steps_ff;
      have_tomb_in = have_tomb_ff;
      tomb_in      = tomb_ff;
      act_in       = act_ff;
      key_in       = key_ff;
      len_in       = len_ff;
      val_in       = val_ff;
      ent_key_in   = ent_key_ff;
      ent_len_in   = ent_len_ff;
      ent_val_in   = ent_val_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      we_mark      = 1'b0;
      we_kv        = 1'b0;
      we_val       = 1'b0;
      wr_addr      = {bank_ff, target};
      wr_mark      = MARK_USED;
      wr_key       = key_ff;
      wr_len       = len_ff;
      wr_val       = val_ff;
      rsp_status   = STS_NOT_FOUND;
      rsp_value    = '0;

      if (cmd_i.capture) begin
         act_in = req_tdata[ACTION_W-1:0];
         key_in = cap_key;
         len_in = cap_len;
         val_in = req_tdata[REQ_VAL_LSB +: VALUE_W];
      end
      if (cmd_i.idx_zero) begin
         idx_in = '0;
      end else if (cmd_i.idx_step) begin
         idx_in = idx_ff + SLOT_BITS'(1);
      end
      if (cmd_i.probe_init) begin
         pos_in       = req_home;
         steps_in     = '0;
         have_tomb_in = 1'b0;
      end
      if (cmd_i.pos_step) begin
         if (rd_mark_ff == MARK_TOMB && !have_tomb_ff) begin
            have_tomb_in = 1'b1;
            tomb_in      = pos_ff;
         end
         pos_in   = (pos_ff + SLOT_BITS'(1)) & mask_cur;
         steps_in = steps_ff + SLOT_BITS'(1);
      end
      if (cmd_i.walk_take) begin
         ent_key_in = rd_key_ff;
         ent_len_in = rd_len_ff;
         ent_val_in = rd_val_ff;
         pos_in     = ent_home;
      end
      if (cmd_i.gpos_step) begin
         pos_in = (pos_ff + SLOT_BITS'(1)) & mask_new;
      end
      if (cmd_i.commit) begin
         bank_in     = !bank_ff;
         size_log_in = size_log_ff + LOG_W'(1);
      end

      if (cmd_i.clr_write) begin
         we_mark = 1'b1;
         wr_mark = MARK_EMPTY;
         wr_addr = {bank_ff ^ cmd_i.clr_new, idx_ff};
      end else if (cmd_i.place) begin
         we_mark = 1'b1;
         we_kv   = 1'b1;
         we_val  = 1'b1;
         wr_mark = MARK_USED;
         wr_addr = {!bank_ff, pos_ff};
         wr_key  = ent_key_ff;
         wr_len  = ent_len_ff;
         wr_val  = ent_val_ff;
      end else if (cmd_i.apply) begin
         case (cmd_i.outcome)
            OUT_FOUND: begin
               wr_addr = {bank_ff, pos_ff};
               if (act_class == CLS_LOOKUP) begin
                  rsp_status = STS_OK;
                  rsp_value  = rd_val_ff;
                  if (act_ff == ACT_UPDATE) begin
                     we_val = 1'b1;
                  end else if (act_ff == ACT_DELETE) begin
                     we_mark  = 1'b1;
                     wr_mark  = MARK_TOMB;
                     count_in = count_ff - CNT_W'(1);
                  end
               end else if (act_ff == ACT_SET) begin
                  rsp_status = STS_OK;
                  we_val     = 1'b1;
               end else begin
                  rsp_status = STS_EXISTS;
               end
            end
            OUT_SLOT: begin
               if (act_class == CLS_STORE) begin
                  rsp_status = STS_OK;
                  we_mark    = 1'b1;
                  we_kv      = 1'b1;
                  we_val     = 1'b1;
                  count_in   = count_ff + CNT_W'(1);
               end
            end
            OUT_NONE: begin
               if (act_class == CLS_STORE) rsp_status = STS_FULL;
            end
            OUT_RESIZE_FAIL: begin
               rsp_status = STS_RESIZE_FAIL;
            end
            default: begin
               rsp_status = STS_NOT_FOUND;
            end
         endcase
         rsp_valid_in = 1'b1;
         rsp_data_in  = {OUT_COUNT_W'(n_cur), OUT_COUNT_W'(count_in), rsp_value, rsp_status};
      end
   end

   always_ff @(posedge clock) begin
      if (we_mark) mark_mem[wr_addr] <= wr_mark;
      if (we_kv) begin
         key_mem[wr_addr] <= wr_key;
         len_mem[wr_addr] <= wr_len;
      end
      if (we_val) val_mem[wr_addr] <= wr_val;
      if (rd_en) begin
         rd_mark_ff <= mark_mem[rd_addr];
         rd_key_ff  <= key_mem[rd_addr];
         rd_len_ff  <= len_mem[rd_addr];
         rd_val_ff  <= val_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= THR_RESET;
         size_log_ff  <= LOG_W'(INIT_LOG);
         count_ff     <= '0;
         bank_ff      <= 1'b0;
         idx_ff       <= '0;
         have_tomb_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         thr_ff       <= thr_in;
         size_log_ff  <= size_log_in;
         count_ff     <= count_in;
         bank_ff      <= bank_in;
         idx_ff       <= idx_in;
         have_tomb_ff <= have_tomb_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      steps_ff    <= steps_in;
      tomb_ff     <= tomb_in;
      act_ff      <= act_in;
      key_ff      <= key_in;
      len_ff      <= len_in;
      val_ff      <= val_in;
      ent_key_ff  <= ent_key_in;
      ent_len_ff  <= ent_len_in;
      ent_val_ff  <= ent_val_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_W - RSP_USED_W)'(0), rsp_data_ff};

   `LPHT_ASSERT_NOW(a_count_fits, 1'b1, N_W'(count_ff) <= n_cur, "more entries than slots")
   `LPHT_ASSERT_NEXT(a_apply_rsp, cmd_i.apply, rsp_valid_ff, "result not presented")
   `LPHT_ASSERT_NEXT(a_commit_size, cmd_i.commit, size_log_ff == $past(size_log_ff) + LOG_W'(1), "size not doubled")

endmodule
`default_nettype wire

[design/linear_probe_hash_table.sv]
// top level of the open-addressing hash table with linear probing
// depends on lpht_pkg, lpht_ctrl and lpht_datapath
`default_nettype none
// Hash table of up to MAX_SLOTS entries (8-byte keys, djb2 home slot,
// linear probing with tombstones, doubling rebuild). One request is worked
// at a time. After reset the live bank is swept to empty, one slot a cycle,
// before the first request is taken. In a lookup each slot probed is read
// and then checked, since the slot memory has one read port with a
// registered output. A rebuild first clears the new bank, then walks the
// old slots and probes the new bank for a free slot for each used entry.
// The result sits in an output register, so the next request is taken while
// the previous result waits; a result is only written once that register
// is free.
module linear_probe_hash_table #(
   parameter int MAX_SLOTS     = lpht_pkg::DEF_MAX_SLOTS,
   parameter int INITIAL_SLOTS = lpht_pkg::DEF_INITIAL_SLOTS
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // request: action [2:0], key_bytes [66:3], key_length [70:67],
   // new_value [102:71], zero fill [103]
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [lpht_pkg::REQ_W-1:0] req_tdata,
   // result: status [2:0], data_out [34:3], element_count [45:35],
   // slot_count [56:46], zero fill [63:57]
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic [lpht_pkg::RSP_W-1:0]      rsp_tdata,
   // load threshold in percent
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [lpht_pkg::THR_W-1:0] csr_data
);
   import lpht_pkg::*;

   // log2 of the slot count after reset, which is a power of two
   localparam int INIT_LOG = init_log(INITIAL_SLOTS, MAX_SLOTS);

   cmd_type cmd;
   sts_type sts;

   // threshold register takes a write in any cycle
   assign csr_ready = 1'b1;

   // sequencing of probe, rebuild and result
   lpht_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts_i      (sts),
      .cmd_o      (cmd)
   );

   // slot stores, counters and output register
   lpht_datapath #(
      .MAX_SLOTS (MAX_SLOTS),
      .INIT_LOG  (INIT_LOG)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .cmd_i      (cmd),
      .sts_o      (sts)
   );

endmodule
`default_nettype wire
